// ===== src/pcmdb_pkg.sv =====
// Shared constants for the PCM double-buffer sample fetch block.
`default_nettype none
package pcmdb_pkg;

   // Each store half holds 2**HALF_AW bytes.
   localparam int HALF_AW    = 9;
   localparam int HALF_BYTES = 1 << HALF_AW;
   localparam int STORE_AW   = HALF_AW + 1;
   // A read index may run past the half by up to four fetched bytes plus a skip of 127.
   localparam int IDX_W      = $clog2(HALF_BYTES + 132);

   localparam int WADDR_W = 9;
   localparam int BYTE_W  = 8;
   localparam int HOLD_W  = 8;
   localparam int SKIP_W  = 7;
   localparam int CSR_AW  = 2;

   localparam logic [BYTE_W-1:0] SIGN_FLIP = 8'h80;
   localparam logic [HOLD_W-1:0] HOLD_RESET = 8'hFF;
   localparam logic [SKIP_W-1:0] SKIP_RESET = 7'd4;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam logic [CSR_AW-1:0] CSR_SIXTEEN_BIT = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_STEREO      = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_EFFECT_HOLD = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_EFFECT_SKIP = 2'd3;

endpackage
`default_nettype wire

// ===== src/pcmdb_if.sv =====
// Handshake interfaces for the request, response and register-write channels.
`default_nettype none

interface pcmdb_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic                           write_half;
   logic [pcmdb_pkg::WADDR_W-1:0]  write_addr;
   logic [pcmdb_pkg::BYTE_W-1:0]   write_data;

   modport source (output valid, req_type, write_half, write_addr, write_data,
                   input ready);
   modport sink   (input valid, req_type, write_half, write_addr, write_data,
                   output ready);
endinterface

interface pcmdb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pcmdb_pkg::BYTE_W-1:0]  left_out;
   logic [pcmdb_pkg::BYTE_W-1:0]  right_out;
   logic                          refill_request;
   logic                          refill_half;

   modport source (output valid, left_out, right_out, refill_request, refill_half,
                   input ready);
   modport sink   (input valid, left_out, right_out, refill_request, refill_half,
                   output ready);
endinterface

interface pcmdb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pcmdb_pkg::CSR_AW-1:0]  addr;
   logic [pcmdb_pkg::BYTE_W-1:0]  data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== src/pcm_double_buffer_sample_fetch.sv =====
// Top level of the PCM double-buffer sample fetch block.
`default_nettype none
// A write transaction stores one byte in either half of a 1024-byte ping-pong
// store; writes stream at one per cycle unless a pending tick stalls them. A
// tick transaction reads the next sample from the active half and returns one
// response: a mono tick reads one byte, a held tick none, and a stereo tick
// reads its two bytes one after the other through the single read port of
// the store. Store reads and responses are registered. Read index, hold
// counter and half swapping are updated when the tick is accepted, so the
// next tick can be taken as soon as the pending one finishes. The store is
// not cleared at reset; read only bytes that were written.
module pcm_double_buffer_sample_fetch (
   input  wire logic  clock,
   input  wire logic  reset,
   pcmdb_req_if.sink  req_ch,
   pcmdb_rsp_if.source rsp_ch,
   pcmdb_csr_if.sink  csr_ch
);
   import pcmdb_pkg::*;

   typedef struct packed {
      logic                fetch;
      logic                stereo;
      logic                sixteen;
      logic                refill;
      logic                refill_half;
      logic [STORE_AW-1:0] addr2;
   } pend_type;

   // Configuration registers.
   logic              sixteen_ff, stereo_ff;
   logic [HOLD_W-1:0] hold_cfg_ff;
   logic [SKIP_W-1:0] skip_ff;

   // Playback state.
   logic [HALF_AW-1:0] read_index_ff, read_index_in;
   logic               active_half_ff, active_half_in;
   logic [HOLD_W-1:0]  hold_count_ff, hold_count_in;
   logic [BYTE_W-1:0]  left_sample_ff, right_sample_ff;

   // Tick waiting for its store bytes.
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_phase_ff, pend_phase_in;
   pend_type          pend_ff, pend_in;
   logic [BYTE_W-1:0] lbyte_ff;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_left_ff, rsp_right_ff;
   logic              rsp_refill_ff, rsp_half_ff;

   logic                pend_need2, pend_done, out_free, finish, second_read;
   logic                acc, acc_write, acc_tick, fetch_now, hold_on, over;
   logic [2:0]          step, consumed;
   logic [STORE_AW:0]   addr_sum;
   logic [STORE_AW-1:0] addr1, rd_addr, wr_addr;
   logic [IDX_W-1:0]    idx_a, idx_b;
   logic                wrap, rd_en;
   logic [BYTE_W-1:0]   mem_q, cur_byte, fin_left, fin_right;

   // ---------------------------------------------------------------- config
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sixteen_ff  <= 1'b0;
         stereo_ff   <= 1'b0;
         hold_cfg_ff <= HOLD_RESET;
         skip_ff     <= SKIP_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.addr)
            CSR_SIXTEEN_BIT: sixteen_ff  <= csr_ch.data[0];
            CSR_STEREO:      stereo_ff   <= csr_ch.data[0];
            CSR_EFFECT_HOLD: hold_cfg_ff <= csr_ch.data;
            CSR_EFFECT_SKIP: skip_ff     <= csr_ch.data[SKIP_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ handshake
   assign pend_need2  = pend_ff.fetch && pend_ff.stereo;
   assign pend_done   = pend_valid_ff && (!pend_need2 || pend_phase_ff);
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign finish      = pend_done && out_free;
   assign second_read = pend_valid_ff && !pend_phase_ff && pend_need2;

   assign req_ch.ready = !pend_valid_ff || finish;
   assign acc          = req_ch.valid && req_ch.ready;
   assign acc_write    = acc && (req_ch.req_type == REQ_WRITE);
   assign acc_tick     = acc && (req_ch.req_type == REQ_TICK);

   // ------------------------------------------------- tick control update
   always_comb begin
      fetch_now = (hold_count_ff == '0);
      step      = sixteen_ff ? 3'd2 : 3'd1;
      if (!fetch_now) begin
         consumed = 3'd0;
      end else if (stereo_ff) begin
         consumed = {step[1:0], 1'b0};
      end else begin
         consumed = step;
      end

      // In 16-bit mode the first byte of a sample is the low byte and is skipped.
      addr_sum = (active_half_ff ? (STORE_AW+1)'(HALF_BYTES) : '0)
               + (STORE_AW+1)'(read_index_ff)
               + (STORE_AW+1)'(sixteen_ff);
      addr1    = addr_sum[STORE_AW-1:0];

      idx_a = IDX_W'(read_index_ff) + IDX_W'(consumed);

      hold_on = !hold_cfg_ff[HOLD_W-1];
      over    = hold_count_ff > hold_cfg_ff;
      if (!hold_on || over) begin
         hold_count_in = '0;
      end else begin
         hold_count_in = hold_count_ff + 1'b1;
      end
      idx_b = idx_a + ((hold_on && over) ? IDX_W'(skip_ff) : '0);

      wrap           = idx_b >= IDX_W'(HALF_BYTES);
      read_index_in  = wrap ? '0 : idx_b[HALF_AW-1:0];
      active_half_in = active_half_ff ^ wrap;

      pend_in.fetch       = fetch_now;
      pend_in.stereo      = stereo_ff;
      pend_in.sixteen     = sixteen_ff;
      pend_in.refill      = wrap;
      pend_in.refill_half = wrap & active_half_ff;
      pend_in.addr2       = addr1 + STORE_AW'(step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff  <= '0;
         active_half_ff <= 1'b0;
         hold_count_ff  <= '0;
      end else if (acc_tick) begin
         read_index_ff  <= read_index_in;
         active_half_ff <= active_half_in;
         hold_count_ff  <= hold_count_in;
      end
   end

   // ---------------------------------------------------------------- store
   assign rd_en   = (acc_tick && fetch_now) || second_read;
   assign rd_addr = second_read ? pend_ff.addr2 : addr1;
   assign wr_addr = {req_ch.write_half, HALF_AW'(req_ch.write_addr % HALF_BYTES)};

   pcmdb_store u_store (
      .clock   (clock),
      .wr_en   (acc_write),
      .wr_addr (wr_addr),
      .wr_data (req_ch.write_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (mem_q)
   );

   // -------------------------------------------------------- pending tick
   assign cur_byte = pend_ff.sixteen ? (mem_q ^ SIGN_FLIP) : mem_q;

   always_comb begin
      if (pend_ff.fetch) begin
         fin_left  = pend_ff.stereo ? lbyte_ff : cur_byte;
         fin_right = cur_byte;
      end else begin
         fin_left  = left_sample_ff;
         fin_right = right_sample_ff;
      end

      if (acc_tick) begin
         pend_valid_in = 1'b1;
      end else if (finish) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end

      if (acc_tick) begin
         pend_phase_in = 1'b0;
      end else if (second_read) begin
         pend_phase_in = 1'b1;
      end else begin
         pend_phase_in = pend_phase_ff;
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff   <= 1'b0;
         pend_phase_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         left_sample_ff  <= '0;
         right_sample_ff <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_phase_ff <= pend_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (finish) begin
            left_sample_ff  <= fin_left;
            right_sample_ff <= fin_right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc_tick) begin
         pend_ff <= pend_in;
      end
      if (second_read) begin
         lbyte_ff <= cur_byte;
      end
      if (finish) begin
         rsp_left_ff   <= fin_left;
         rsp_right_ff  <= fin_right;
         rsp_refill_ff <= pend_ff.refill;
         rsp_half_ff   <= pend_ff.refill_half;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.left_out       = rsp_left_ff;
   assign rsp_ch.right_out      = rsp_right_ff;
   assign rsp_ch.refill_request = rsp_refill_ff;
   assign rsp_ch.refill_half    = rsp_half_ff;

endmodule
`default_nettype wire

// ===== src/pcmdb_store.sv =====
// Two-half byte store: one write port and one registered read port.
`default_nettype none
module pcmdb_store (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [pcmdb_pkg::STORE_AW-1:0]   wr_addr,
   input  wire logic [pcmdb_pkg::BYTE_W-1:0]     wr_data,
   input  wire logic                             rd_en,
   input  wire logic [pcmdb_pkg::STORE_AW-1:0]   rd_addr,
   output logic      [pcmdb_pkg::BYTE_W-1:0]     rd_data
);
   import pcmdb_pkg::*;

   logic [BYTE_W-1:0] mem [2*HALF_BYTES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The read register holds its value until the next read, so a stalled
   // response keeps its byte.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
